// ===== design/cbr_pkg.sv =====
// ----------------------------------------------------------------------------
// cbr_pkg: shared types and helpers for the comb bank reverb
// Coefficient record of one comb, fixed-point widths and saturation helpers.
// ----------------------------------------------------------------------------
package cbr_pkg;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 18;
	localparam int DELAY_W  = 14;
	localparam int PRE_W    = 16;
	localparam int STATE_W  = 32;
	localparam int POS_W    = 16;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7F_FFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h80_0000;
	localparam logic [STATE_W-1:0]  STATE_MAX  = 32'h7FFF_FFFF;
	localparam logic [STATE_W-1:0]  STATE_MIN  = 32'h8000_0000;

	// Input request operation codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// Coefficients of one comb, as held in the coefficient memory.
	typedef struct packed {
		logic [GAIN_W-1:0]  damping_coeff;
		logic [GAIN_W-1:0]  feedback_gain;
		logic [GAIN_W-1:0]  in_gain;
		logic [PRE_W-1:0]   predelay_length;
		logic [DELAY_W-1:0] delay_length;
	} coef_t;

	// Saturate a 34-bit two's complement value to the 32-bit state range.
	function automatic logic [STATE_W-1:0] sat_state(input logic [STATE_W+1:0] v);
		logic [STATE_W-1:0] r;
		if (v[STATE_W+1:STATE_W-1] == 3'b000 || v[STATE_W+1:STATE_W-1] == 3'b111) begin
			r = v[STATE_W-1:0];
		end else if (v[STATE_W+1]) begin
			r = STATE_MIN;
		end else begin
			r = STATE_MAX;
		end
		return r;
	endfunction

endpackage

// ===== design/comb_bank_reverb.sv =====
// ----------------------------------------------------------------------------
// comb_bank_reverb: bank of parallel lowpass feedback comb filters (mono)
// A sample request sweeps the combs through the comb ring memory port, which
// visits one comb per cycle. The next request is taken only after the sweep
// has drained and the result has gone to the output register, which waits if
// an earlier result is not yet taken. A load request leaves the block idle.
// Reset clears control, valid bits and fill counts; the memories need no
// clearing pass and the block is ready at once.
// ----------------------------------------------------------------------------
module comb_bank_reverb #(
	parameter int NUM_COMBS      = 64,
	parameter int COMB_DEPTH     = 16384,
	parameter int PREDELAY_DEPTH = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input request channel.
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, lowest bit up: sample_in[23:0], comb_select[29:24],
	// delay_length[43:30], predelay_length[59:44], in_gain[77:60],
	// feedback_gain[95:78], damping_coeff[113:96], zero fill[119:114].
	input  logic [119:0] s_tdata,
	// s_tuser: operation[0] (0 = process sample, 1 = load comb).
	input  logic         s_tuser,
	// Result channel.
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: sample_out[23:0].
	output logic [23:0]  m_tdata
);

	// Comb index width, issue counter width and memory address widths.
	localparam int CW    = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
	localparam int ICW   = $clog2(NUM_COMBS + 1);
	localparam int CAW   = $clog2(COMB_DEPTH);
	localparam int PAW   = $clog2(PREDELAY_DEPTH);
	localparam int RAW   = $clog2(NUM_COMBS * COMB_DEPTH);
	localparam int CFW   = $clog2(COMB_DEPTH + 1);
	// The write position wraps at 2^16, so at most that many predelay entries
	// are ever written.
	localparam int PFILL = (PREDELAY_DEPTH < 65536) ? PREDELAY_DEPTH : 65536;
	localparam int PFW   = $clog2(PFILL + 1);
	localparam int ACC_W = cbr_pkg::STATE_W + $clog2(NUM_COMBS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	// ------------------------------------------------------------------
	// Request fields.
	// ------------------------------------------------------------------
	logic                          in_op;
	logic [cbr_pkg::SAMPLE_W-1:0]  in_sample;
	logic [5:0]                    in_sel;
	cbr_pkg::coef_t                in_coef;

	assign in_op                   = s_tuser;
	assign in_sample               = s_tdata[23:0];
	assign in_sel                  = s_tdata[29:24];
	assign in_coef.delay_length    = s_tdata[43:30];
	assign in_coef.predelay_length = s_tdata[59:44];
	assign in_coef.in_gain         = s_tdata[77:60];
	assign in_coef.feedback_gain   = s_tdata[95:78];
	assign in_coef.damping_coeff   = s_tdata[113:96];

	// ------------------------------------------------------------------
	// Control state.
	// ------------------------------------------------------------------
	logic [1:0]                 state_q;
	logic [ICW-1:0]             issue_q;
	logic [cbr_pkg::POS_W-1:0]  wp_q;
	logic [CFW-1:0]             cfill_q;
	logic [PFW-1:0]             pfill_q;
	logic [NUM_COMBS-1:0]       coef_vld_q;
	logic [ACC_W-1:0]           acc_q;
	logic                       out_vld_q;
	logic [23:0]                out_data_q;

	logic v_s1, v_s2, v_s3, v_s4;

	logic accept;
	logic accept_sample;
	logic accept_load;
	logic issue;
	logic out_free;
	logic [CW-1:0] issue_idx;

	assign s_tready      = (state_q == ST_IDLE);
	assign accept        = s_tvalid & s_tready;
	assign accept_sample = accept & (in_op == cbr_pkg::OP_SAMPLE);
	assign accept_load   = accept & (in_op == cbr_pkg::OP_LOAD)
	                       & (32'(in_sel) < NUM_COMBS);
	assign issue         = (state_q == ST_RUN) && (32'(issue_q) < NUM_COMBS);
	assign issue_idx     = issue_q[CW-1:0];
	assign out_free      = !out_vld_q || m_tready;

	// The output register parts the two sides: the next request is taken
	// while a finished result still waits.
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Write position extended to 32 bits, as used in the index arithmetic.
	logic [31:0] wp_ext;
	assign wp_ext = {16'd0, wp_q};

	logic [PAW-1:0] pre_widx;
	logic [31:0]    pre_wmask;
	assign pre_wmask = wp_ext & 32'(PREDELAY_DEPTH - 1);
	assign pre_widx  = pre_wmask[PAW-1:0];

	logic [CAW-1:0] ring_widx;
	logic [31:0]    ring_wmask;
	assign ring_wmask = wp_ext & 32'(COMB_DEPTH - 1);
	assign ring_widx  = ring_wmask[CAW-1:0];

	// ------------------------------------------------------------------
	// Memories. The rings, the lowpass states and the coefficients all live
	// in synchronous memories with registered reads. Reset values are
	// provided without a clearing pass: coefficient entries carry a valid
	// bit, and the rings are filled strictly in order of the write position,
	// so an index below the fill count has been written and any other index
	// still reads as zero. The lowpass states are all written by the first
	// completed sample, so a nonzero comb fill count marks them valid.
	// ------------------------------------------------------------------
	cbr_pkg::coef_t                coef_mem [NUM_COMBS];
	logic [cbr_pkg::STATE_W-1:0]   st_mem   [NUM_COMBS];
	logic [cbr_pkg::SAMPLE_W-1:0]  pre_mem  [PREDELAY_DEPTH];
	logic [cbr_pkg::STATE_W-1:0]   ring_mem [NUM_COMBS * COMB_DEPTH];

	// ------------------------------------------------------------------
	// Stage 1: coefficient read for the comb just issued.
	// ------------------------------------------------------------------
	logic [CW-1:0]   c_s1;
	cbr_pkg::coef_t  coef_rd_s1;
	logic            cvld_s1;

	always_ff @(posedge clk) begin
		if (accept_load) begin
			coef_mem[in_sel[CW-1:0]] <= in_coef;
		end
	end

	always_ff @(posedge clk) begin
		coef_rd_s1 <= coef_mem[issue_idx];
		cvld_s1    <= coef_vld_q[issue_idx];
		c_s1       <= issue_idx;
	end

	// A comb that was never loaded behaves as if all of its lengths and
	// gains were zero, which makes it silent.
	cbr_pkg::coef_t coef_use;
	logic [31:0]    p_diff;
	logic [31:0]    r_diff;
	logic [PAW-1:0] pre_ridx;
	logic [CAW-1:0] ring_ridx;
	logic [RAW-1:0] ring_raddr;
	logic [RAW-1:0] ring_waddr;

	always_comb begin
		coef_use   = cvld_s1 ? coef_rd_s1 : '0;
		p_diff     = (wp_ext - 32'(coef_use.predelay_length)) & 32'(PREDELAY_DEPTH - 1);
		r_diff     = (wp_ext - 32'(coef_use.delay_length)) & 32'(COMB_DEPTH - 1);
		pre_ridx   = p_diff[PAW-1:0];
		ring_ridx  = r_diff[CAW-1:0];
		ring_raddr = RAW'(c_s1) * RAW'(COMB_DEPTH) + RAW'(ring_ridx);
	end

	// ------------------------------------------------------------------
	// Stage 2: predelay, ring and lowpass state reads.
	// ------------------------------------------------------------------
	logic [CW-1:0]                 c_s2;
	logic [cbr_pkg::GAIN_W-1:0]    gin_s2, gfb_s2, gdm_s2;
	logic [cbr_pkg::SAMPLE_W-1:0]  pre_rd_s2;
	logic [cbr_pkg::STATE_W-1:0]   ring_rd_s2;
	logic [cbr_pkg::STATE_W-1:0]   st_rd_s2;
	logic                          pre_ok_s2, ring_ok_s2, st_ok_s2;

	// The input sample goes into the predelay ring at acceptance, before comb 0
	// is issued, so a zero predelay tap sees it when comb 0 reads.
	always_ff @(posedge clk) begin
		if (accept_sample) begin
			pre_mem[pre_widx] <= in_sample;
		end
	end

	always_ff @(posedge clk) begin
		pre_rd_s2  <= pre_mem[pre_ridx];
		ring_rd_s2 <= ring_mem[ring_raddr];
		st_rd_s2   <= st_mem[c_s1];
		pre_ok_s2  <= p_diff < 32'(pfill_q);
		ring_ok_s2 <= r_diff < 32'(cfill_q);
		st_ok_s2   <= (cfill_q != '0);
		gin_s2     <= coef_use.in_gain;
		gfb_s2     <= coef_use.feedback_gain;
		gdm_s2     <= coef_use.damping_coeff;
		c_s2       <= c_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: the three gain products, registered.
	// ------------------------------------------------------------------
	logic signed [cbr_pkg::STATE_W-1:0]  st_use, fb_use;
	logic signed [cbr_pkg::SAMPLE_W-1:0] pre_use;

	assign st_use  = st_ok_s2   ? $signed(st_rd_s2)   : '0;
	assign fb_use  = ring_ok_s2 ? $signed(ring_rd_s2) : '0;
	assign pre_use = pre_ok_s2  ? $signed(pre_rd_s2)  : '0;

	logic [CW-1:0]       c_s3;
	logic signed [50:0]  m_dm_s3;
	logic signed [50:0]  m_fb_s3;
	logic signed [42:0]  m_in_s3;

	always_ff @(posedge clk) begin
		m_dm_s3 <= st_use  * $signed({1'b0, gdm_s2});
		m_fb_s3 <= fb_use  * $signed({1'b0, gfb_s2});
		m_in_s3 <= pre_use * $signed({1'b0, gin_s2});
		c_s3    <= c_s2;
	end

	// ------------------------------------------------------------------
	// Stage 4: new lowpass state. Dropping the low 18 bits of a two's
	// complement product is a floor division by 2^18.
	// ------------------------------------------------------------------
	logic [cbr_pkg::STATE_W+1:0] st_sum;
	assign st_sum = {m_dm_s3[50], m_dm_s3[50:18]} + {m_fb_s3[50], m_fb_s3[50:18]};

	logic [CW-1:0]               c_s4;
	logic [cbr_pkg::STATE_W-1:0] st_s4;
	logic [24:0]                 pre_term_s4;

	always_ff @(posedge clk) begin
		st_s4       <= cbr_pkg::sat_state(st_sum);
		pre_term_s4 <= m_in_s3[42:18];
		c_s4        <= c_s3;
	end

	// Write back: the state memory takes the new state, the comb ring takes
	// state plus the scaled predelayed input. Each comb is visited once per
	// sample and the next sample starts only after the pipeline drains, so
	// a read never overlaps a pending write of the same entry.
	logic [cbr_pkg::STATE_W+1:0] ring_sum;
	assign ring_sum   = {{2{st_s4[31]}}, st_s4} + {{9{pre_term_s4[24]}}, pre_term_s4};
	assign ring_waddr = RAW'(c_s4) * RAW'(COMB_DEPTH) + RAW'(ring_widx);

	always_ff @(posedge clk) begin
		if (v_s4) begin
			st_mem[c_s4]         <= st_s4;
			ring_mem[ring_waddr] <= cbr_pkg::sat_state(ring_sum);
		end
	end

	// ------------------------------------------------------------------
	// Output saturation of the exact sum of all comb states.
	// ------------------------------------------------------------------
	logic [23:0] acc_sat;
	always_comb begin
		if (acc_q[ACC_W-1:23] == '0 || acc_q[ACC_W-1:23] == '1) begin
			acc_sat = acc_q[23:0];
		end else if (acc_q[ACC_W-1]) begin
			acc_sat = cbr_pkg::SAMPLE_MIN;
		end else begin
			acc_sat = cbr_pkg::SAMPLE_MAX;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer. IDLE takes requests; RUN issues one comb per cycle and
	// waits for the four-stage pipeline to drain; OUT hands the result to
	// the output register once it is free, then advances the position.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issue_q    <= '0;
			wp_q       <= '0;
			cfill_q    <= '0;
			pfill_q    <= '0;
			coef_vld_q <= '0;
			acc_q      <= '0;
			out_vld_q  <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;

			// A new result loads the output register; otherwise a taken
			// result empties it.
			if (state_q == ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end

			if (v_s4) begin
				acc_q <= acc_q + {{(ACC_W - cbr_pkg::STATE_W){st_s4[31]}}, st_s4};
			end

			case (state_q)
				ST_IDLE: begin
					if (accept_load) begin
						coef_vld_q[in_sel[CW-1:0]] <= 1'b1;
					end
					if (accept_sample) begin
						state_q <= ST_RUN;
						issue_q <= '0;
						acc_q   <= '0;
						if (pfill_q != PFW'(PFILL)) begin
							pfill_q <= pfill_q + 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end else if (!v_s1 && !v_s2 && !v_s3 && !v_s4) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						wp_q      <= wp_q + 1'b1;
						state_q   <= ST_IDLE;
						if (cfill_q != CFW'(COMB_DEPTH)) begin
							cfill_q <= cfill_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= acc_sat;
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// No comb may still be in flight while a new request can be taken.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(v_s1 || v_s2 || v_s3 || v_s4))
		else $error("request accepted while the comb pipeline is busy");

	// The result is formed only after every comb has been issued.
	a_out_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (32'(issue_q) == NUM_COMBS))
		else $error("result formed before all combs were processed");

	// A sample request issues comb 0 in the next cycle.
	a_first_issue: assert property (@(posedge clk) disable iff (!arst_n)
		accept_sample |=> (issue && issue_q == '0))
		else $error("sample request did not start the comb sweep");

	// Fill counts never pass the depth of their ring.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cfill_q) <= COMB_DEPTH) && (32'(pfill_q) <= PFILL))
		else $error("ring fill count out of range");

endmodule
